### rtl/slot_allocator_reuse_delay_top_defines.svh
// Assertion macros shared by the slot allocator checkers.
`ifndef SLOT_ALLOCATOR_REUSE_DELAY_TOP_DEFINES_SVH
`define SLOT_ALLOCATOR_REUSE_DELAY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/srd_pkg.sv
// Shared types and constants for the slot allocator with reuse delay.
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

  localparam int POOL_SLOTS_DEF       = 1024;
  localparam int RESERVED_CLIENTS_DEF = 32;

  localparam int SLOT_W = 10;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] GRACE_RST = 16'd2000;
  localparam logic [CFG_W-1:0] DELAY_RST = 16'd500;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } srd_cmd_t;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_GRACE = 1'b0,
    REG_DELAY = 1'b1
  } srd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_SCAN,
    ST_EXTEND,
    ST_DONE
  } srd_state_t;

endpackage

`default_nettype wire

### rtl/srd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/slot_allocator_reuse_delay_top.sv
// Slot allocator with reuse delay: config registers, scan sequencer and slot RAM.
//
// Channel   Handshake            Payload
// req       req_valid/req_ready  command, slot_index, now_ms
// rsp       rsp_valid/rsp_ready  slot, stolen, bad_index
// apb       psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A free passes through ST_FREE and ST_DONE before rsp_valid rises; an allocate with no
// slot to scan passes through ST_EXTEND and ST_DONE. An allocate reads one slot per cycle
// through the single read port of the slot RAM. One transaction is in flight; the next is
// accepted while a result waits in the output register. Synchronous reset needs no
// clearing pass: every slot below the high-water count is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module slot_allocator_reuse_delay_top #(
  parameter int POOL_SLOTS       = srd_pkg::POOL_SLOTS_DEF,
  parameter int RESERVED_CLIENTS = srd_pkg::RESERVED_CLIENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srd_pkg::APB_AW-1:0]  paddr,
  input  logic [srd_pkg::APB_DW-1:0]  pwdata,
  output logic [srd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        command,
  input  logic [srd_pkg::SLOT_W-1:0]  slot_index,
  input  logic [srd_pkg::TIME_W-1:0]  now_ms,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [srd_pkg::SLOT_W-1:0]  slot,
  output logic                        stolen,
  output logic                        bad_index
);

  import srd_pkg::*;

  localparam int IDX_W = $clog2(POOL_SLOTS);
  localparam int CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int MEM_W = TIME_W + 1;
  localparam int FIRST_SLOT = (RESERVED_CLIENTS + 1 < POOL_SLOTS) ?
                              (RESERVED_CLIENTS + 1) : (POOL_SLOTS - 1);

  // Configuration registers
  logic [CFG_W-1:0] startup_grace;
  logic [CFG_W-1:0] reuse_delay;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_grace <= GRACE_RST;
      reuse_delay   <= DELAY_RST;
    end else if (cfg_wr) begin
      unique case (srd_reg_t'(paddr[2]))
        REG_GRACE: startup_grace <= pwdata[CFG_W-1:0];
        REG_DELAY: reuse_delay   <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (srd_reg_t'(paddr[2]))
      REG_GRACE: prdata = APB_DW'(startup_grace);
      REG_DELAY: prdata = APB_DW'(reuse_delay);
    endcase
  end

  // Sequencer state
  srd_state_t         state, state_next;
  logic [SLOT_W-1:0]  idx_q, idx_q_next;
  logic [TIME_W-1:0]  now_q, now_q_next;
  logic [CNT_W-1:0]   high_water, high_water_next;
  logic [CNT_W-1:0]   scan_ptr, scan_ptr_next;
  logic [IDX_W-1:0]   chk_ptr, chk_ptr_next;
  logic               rd_pend, rd_pend_next;
  logic [SLOT_W-1:0]  res_slot, res_slot_next;
  logic               res_stolen, res_stolen_next;
  logic               res_bad, res_bad_next;
  logic               rsp_valid_next;
  logic [SLOT_W-1:0]  slot_next;
  logic               stolen_next;
  logic               bad_index_next;

  // Slot RAM: {in_use, free_time}
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [MEM_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [MEM_W-1:0]   ram_rdata;

  srd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (POOL_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared check unit: one slot per cycle
  logic [TIME_W-1:0] free_time;
  logic [TIME_W-1:0] elapsed;
  logic              slot_ok;
  logic              idx_bad;
  logic              scan_more;
  logic              pool_full;

  assign free_time = ram_rdata[TIME_W-1:0];
  assign elapsed   = now_q - free_time;
  assign slot_ok   = !ram_rdata[TIME_W] &&
                     ((free_time < TIME_W'(startup_grace)) ||
                      (elapsed > TIME_W'(reuse_delay)));
  assign idx_bad   = CMP_W'(idx_q) >= CMP_W'(POOL_SLOTS);
  assign scan_more = scan_ptr < high_water;
  assign pool_full = high_water >= CNT_W'(POOL_SLOTS);

  always_comb begin
    state_next      = state;
    idx_q_next      = idx_q;
    now_q_next      = now_q;
    high_water_next = high_water;
    scan_ptr_next   = scan_ptr;
    chk_ptr_next    = chk_ptr;
    rd_pend_next    = rd_pend;
    res_slot_next   = res_slot;
    res_stolen_next = res_stolen;
    res_bad_next    = res_bad;
    rsp_valid_next  = rsp_valid;
    slot_next       = slot;
    stolen_next     = stolen;
    bad_index_next  = bad_index;
    ram_we          = 1'b0;
    ram_waddr       = chk_ptr;
    ram_wdata       = {1'b1, now_q};
    ram_raddr       = scan_ptr[IDX_W-1:0];
    req_ready       = 1'b0;

    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          idx_q_next    = slot_index;
          now_q_next    = now_ms;
          scan_ptr_next = CNT_W'(FIRST_SLOT);
          rd_pend_next  = 1'b0;
          if (srd_cmd_t'(command) == CMD_FREE) begin
            state_next = ST_FREE;
          end else if (CNT_W'(FIRST_SLOT) < high_water) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EXTEND;
          end
        end
      end

      ST_FREE: begin
        res_slot_next   = idx_q;
        res_stolen_next = 1'b0;
        res_bad_next    = idx_bad;
        if (!idx_bad) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(idx_q);
          ram_wdata = {1'b0, now_q};
        end
        state_next = ST_DONE;
      end

      ST_SCAN: begin
        // issue the next read while checking the one issued last cycle
        rd_pend_next = scan_more;
        chk_ptr_next = scan_ptr[IDX_W-1:0];
        if (scan_more) begin
          scan_ptr_next = scan_ptr + CNT_W'(1);
        end
        if (rd_pend && slot_ok) begin
          ram_we          = 1'b1;
          ram_waddr       = chk_ptr;
          res_slot_next   = SLOT_W'(chk_ptr);
          res_stolen_next = 1'b0;
          res_bad_next    = 1'b0;
          rd_pend_next    = 1'b0;
          state_next      = ST_DONE;
        end else if (!rd_pend && !scan_more) begin
          state_next = ST_EXTEND;
        end
      end

      ST_EXTEND: begin
        ram_we       = 1'b1;
        res_bad_next = 1'b0;
        if (pool_full) begin
          // pool exhausted: hand out the last slot again
          ram_waddr       = IDX_W'(POOL_SLOTS - 1);
          res_slot_next   = SLOT_W'(POOL_SLOTS - 1);
          res_stolen_next = 1'b1;
        end else begin
          ram_waddr       = high_water[IDX_W-1:0];
          res_slot_next   = SLOT_W'(high_water);
          res_stolen_next = 1'b0;
          high_water_next = high_water + CNT_W'(1);
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next = 1'b1;
          slot_next      = res_slot;
          stolen_next    = res_stolen;
          bad_index_next = res_bad;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      high_water <= CNT_W'(FIRST_SLOT);
      rd_pend    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      high_water <= high_water_next;
      rd_pend    <= rd_pend_next;
      rsp_valid  <= rsp_valid_next;
    end
    idx_q      <= idx_q_next;
    now_q      <= now_q_next;
    scan_ptr   <= scan_ptr_next;
    chk_ptr    <= chk_ptr_next;
    res_slot   <= res_slot_next;
    res_stolen <= res_stolen_next;
    res_bad    <= res_bad_next;
    slot       <= slot_next;
    stolen     <= stolen_next;
    bad_index  <= bad_index_next;
  end

endmodule

`default_nettype wire

### rtl/srd_checker.sv
// Port-level checker for the slot allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "slot_allocator_reuse_delay_top_defines.svh"

module srd_checker #(
  parameter int POOL_SLOTS = srd_pkg::POOL_SLOTS_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       req_valid,
  input wire logic                       req_ready,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic [srd_pkg::SLOT_W-1:0] slot,
  input wire logic                       stolen,
  input wire logic                       bad_index
);

  import srd_pkg::*;

  logic [1:0] outstanding;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // count transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 2'd0;
    end else if (req_fire && !rsp_fire) begin
      outstanding <= outstanding + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  `SRD_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_ready, "ready right after accept")
  `SRD_ASSERT_NOW(a_no_extra_result, rsp_valid, outstanding != 2'd0, "result without request")
  `SRD_ASSERT_NOW(a_accept_depth, req_fire, outstanding <= 2'd1, "too many in flight")
  `SRD_ASSERT_NOW(a_stolen_last, rsp_valid && stolen, slot == SLOT_W'(POOL_SLOTS - 1) && !bad_index, "stolen slot is not the last")
  `SRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(slot) && $stable(stolen) && $stable(bad_index), "result changed while stalled")

endmodule

bind slot_allocator_reuse_delay_top srd_checker #(
  .POOL_SLOTS (POOL_SLOTS)
) u_srd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .slot      (slot),
  .stolen    (stolen),
  .bad_index (bad_index)
);

`default_nettype wire
